// ===== sv/occ_pkg.sv =====
// ----------------------------------------------------------------------------
// occ_pkg
// Shared types, mode codes and helpers for the one's complement checksum core.
// ----------------------------------------------------------------------------
package occ_pkg;

    localparam int BYTE_W = 8;
    localparam int SUM_W  = 32;
    localparam int MODE_W = 2;
    localparam int LANE_W = 2;

    // word width codes; the unused code acts as 32-bit words
    localparam logic [MODE_W-1:0] MODE_W8  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_W16 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_W32 = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RST = MODE_W16;

    localparam logic [SUM_W-1:0] MASK8  = 32'h0000_00FF;
    localparam logic [SUM_W-1:0] MASK16 = 32'h0000_FFFF;
    localparam logic [SUM_W-1:0] MASK32 = 32'hFFFF_FFFF;

    // registered input item handed from the input stage to the accumulator
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } occ_item_t;

    function automatic logic [SUM_W-1:0] width_mask(input logic [MODE_W-1:0] mode);
        logic [SUM_W-1:0] m;
        case (mode)
            MODE_W8:  m = MASK8;
            MODE_W16: m = MASK16;
            default:  m = MASK32;
        endcase
        return m;
    endfunction

    // index of the highest lane in the word (bytes per word minus one)
    function automatic logic [LANE_W-1:0] top_lane(input logic [MODE_W-1:0] mode);
        logic [LANE_W-1:0] t;
        case (mode)
            MODE_W8:  t = 2'd0;
            MODE_W16: t = 2'd1;
            default:  t = 2'd3;
        endcase
        return t;
    endfunction

endpackage

// ===== sv/occ_in_if.sv =====
// ----------------------------------------------------------------------------
// occ_in_if
// Byte item channel: valid/ready handshake with data byte and last mark.
// ----------------------------------------------------------------------------
interface occ_in_if;
    import occ_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== sv/occ_out_if.sv =====
// ----------------------------------------------------------------------------
// occ_out_if
// Checksum item channel: valid/ready handshake with the 32-bit checksum.
// ----------------------------------------------------------------------------
interface occ_out_if;
    import occ_pkg::*;

    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] checksum;

    modport source (output valid, output checksum, input ready);
    modport sink   (input valid, input checksum, output ready);
endinterface

// ===== sv/ones_complement_checksum_core.sv =====
// ----------------------------------------------------------------------------
// ones_complement_checksum_core
// One's complement (Internet style) checksum over a byte stream, with
// 8/16/32-bit big-endian words selected by a width register.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake     | payload
//  byte_in   | in  | valid / ready | data_byte[7:0], last_byte
//  sum_out   | out | valid / ready | checksum[31:0]
//  cfg       | in  | cfg_we        | cfg_wdata[1:0] = word_width_mode
//
//  One byte item per clock. Each byte is held in the input register and is
//  summed into the accumulator as it leaves; the checksum register and
//  sum_out.valid are loaded when the last byte is summed. Reset clears the
//  accumulator and sets 16-bit words. While a checksum waits on sum_out.ready
//  the accumulator holds, the input register fills and byte_in.ready drops. A
//  width write restarts the message.
// ----------------------------------------------------------------------------
module ones_complement_checksum_core (
    input  logic                        clk,
    input  logic                        rst_n,
    occ_in_if.sink                      byte_in,
    occ_out_if.source                   sum_out,
    input  logic                        cfg_we,
    input  logic [occ_pkg::MODE_W-1:0]  cfg_wdata
);
    import occ_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic [MODE_W-1:0] mode_next;
    occ_item_t         stage;
    logic              advance;

    assign mode_next = cfg_we ? cfg_wdata : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RST;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    occ_input_stage u_input_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .advance (advance),
        .stage   (stage)
    );

    occ_accum u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (cfg_we),
        .mode    (mode_reg),
        .stage   (stage),
        .advance (advance),
        .sum_out (sum_out)
    );

    // a new result only follows a last byte leaving the input register
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sum_out.valid) |-> $past(stage.valid && stage.last_byte))
        else $error("checksum without a last byte");

    // input back-pressure only while the input register holds an item
    a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_in.ready |-> (stage.valid && sum_out.valid && !sum_out.ready))
        else $error("input stalled with room to spare");

    // checksum stays inside the selected word width
    a_width8: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_out.valid && mode_reg == MODE_W8) |-> (sum_out.checksum[31:8] == 24'd0))
        else $error("8-bit checksum has high bits set");

    a_width16: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_out.valid && mode_reg == MODE_W16) |-> (sum_out.checksum[31:16] == 16'd0))
        else $error("16-bit checksum has high bits set");
endmodule

// ===== sv/occ_input_stage.sv =====
// ----------------------------------------------------------------------------
// occ_input_stage
// Input register for byte items; refills in the same cycle it drains.
// ----------------------------------------------------------------------------
module occ_input_stage (
    input  logic                clk,
    input  logic                rst_n,
    occ_in_if.sink              byte_in,
    input  logic                advance,
    output occ_pkg::occ_item_t  stage
);
    import occ_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              last_reg;
    logic              take;

    assign byte_in.ready = !valid_reg || advance;
    assign take          = byte_in.valid && byte_in.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= byte_in.data_byte;
            last_reg <= byte_in.last_byte;
        end
    end

    assign stage.valid     = valid_reg;
    assign stage.data_byte = data_reg;
    assign stage.last_byte = last_reg;
endmodule

// ===== sv/occ_accum.sv =====
// ----------------------------------------------------------------------------
// occ_accum
// Lane-aligned one's complement add with end-around carry, message state and
// the checksum result register.
// ----------------------------------------------------------------------------
module occ_accum (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear,
    input  logic [occ_pkg::MODE_W-1:0]  mode,
    input  occ_pkg::occ_item_t          stage,
    output logic                        advance,
    occ_out_if.source                   sum_out
);
    import occ_pkg::*;

    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [LANE_W-1:0] lane_reg;
    logic [LANE_W-1:0] lane_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [SUM_W-1:0]  cks_reg;

    logic              take;
    logic [SUM_W-1:0]  mask;
    logic [LANE_W-1:0] lane_top;
    logic [LANE_W-1:0] lane;
    logic [LANE_W-1:0] lane_pos;
    logic [SUM_W-1:0]  shifted;
    logic [SUM_W:0]    raw;
    logic              carry;
    logic [SUM_W-1:0]  folded;

    assign advance = !out_valid_reg || sum_out.ready;
    assign take    = stage.valid && advance;

    assign mask     = width_mask(mode);
    assign lane_top = top_lane(mode);
    assign lane     = lane_reg & lane_top;
    // bytes below this one in the word; lane 0 is the most significant
    assign lane_pos = lane_top - lane;
    assign shifted  = {{(SUM_W-BYTE_W){1'b0}}, stage.data_byte} << {lane_pos, 3'b000};
    assign raw      = {1'b0, sum_reg & mask} + {1'b0, shifted};

    always_comb
    begin
        case (mode)
            MODE_W8:  carry = raw[8];
            MODE_W16: carry = raw[16];
            default:  carry = raw[SUM_W];
        endcase
    end

    // both addends are at most mask, so one fold cannot carry again
    assign folded = ((raw[SUM_W-1:0] & mask) + {{(SUM_W-1){1'b0}}, carry}) & mask;

    always_comb
    begin
        sum_next       = sum_reg;
        lane_next      = lane_reg;
        out_valid_next = out_valid_reg && !sum_out.ready;
        if (clear)
        begin
            sum_next  = '0;
            lane_next = '0;
        end
        else if (take)
        begin
            if (stage.last_byte)
            begin
                sum_next       = '0;
                lane_next      = '0;
                out_valid_next = 1'b1;
            end
            else
            begin
                sum_next  = folded;
                lane_next = (lane == lane_top) ? '0 : lane + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            lane_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            lane_reg      <= lane_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && stage.last_byte && !clear)
        begin
            cks_reg <= ~folded & mask;
        end
    end

    assign sum_out.valid    = out_valid_reg;
    assign sum_out.checksum = cks_reg;
endmodule

// ===== dv/ones_complement_checksum_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ones_complement_checksum_core_tb
// Self-checking bench for the checksum core: byte messages are driven through
// the input channel, a local model folds each accepted byte into its own
// one's complement sum, and every checksum item is compared in order against
// the predicted value. Covers all width codes, width writes in mid-message,
// random gaps on both channels and a stretch with none.
// ----------------------------------------------------------------------------
module ones_complement_checksum_core_tb;
    import occ_pkg::*;

    localparam int          HALF_PERIOD = 4;
    localparam int unsigned IDLE_LIMIT  = 2000;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [MODE_W-1:0] cfg_wdata;

    occ_in_if  byte_ch ();
    occ_out_if sum_ch ();

    ones_complement_checksum_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_ch),
        .sum_out   (sum_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // model state
    logic [MODE_W-1:0] width_mode;
    logic [SUM_W-1:0]  run_sum;
    logic [LANE_W-1:0] lane_pos;
    logic [SUM_W-1:0]  pending_sums[$];

    bit          no_gaps;
    int unsigned n_bytes;
    int unsigned n_sums;
    int unsigned n_errors;
    int unsigned idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    function automatic int unsigned word_bytes(input logic [MODE_W-1:0] m);
        case (m)
            MODE_W8:  return 1;
            MODE_W16: return 2;
            default:  return 4;
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] MODE_W_RAND();
        return MODE_W'($urandom_range(3));
    endfunction

    // fold one byte into the model sum at its lane, end-around carry
    function automatic void fold_in_byte(input logic [BYTE_W-1:0] b, input logic lst);
        int unsigned nb;
        int unsigned ln;
        logic [63:0] mask;
        logic [63:0] s;
        nb   = word_bytes(width_mode);
        ln   = lane_pos % nb;
        mask = (64'd1 << (8 * nb)) - 64'd1;
        s    = ({32'd0, run_sum} & mask) + ({56'd0, b} << (8 * (nb - 1 - ln)));
        s    = (s & mask) + (s >> (8 * nb));
        run_sum = s[SUM_W-1:0] & mask[SUM_W-1:0];
        if (lst)
        begin
            pending_sums.push_back(~run_sum & mask[SUM_W-1:0]);
            run_sum  = '0;
            lane_pos = '0;
        end
        else
        begin
            lane_pos = LANE_W'((ln + 1) % nb);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [SUM_W-1:0] got,
                                   input logic [SUM_W-1:0] want);
        $display("[%0t] mismatch: %s got 0x%08h want 0x%08h", $realtime, what, got, want);
        n_errors++;
    endtask

    // ------------------------------------------------------------------------
    // item driving
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic lst);
        while (!no_gaps && $urandom_range(99) < 26)
        begin
            @(negedge clk);
            byte_ch.valid <= 1'b0;
        end
        @(negedge clk);
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= lst;
        do @(posedge clk); while (!byte_ch.ready);
        fold_in_byte(b, lst);
        n_bytes++;
    endtask

    task automatic send_msg(input logic [BYTE_W-1:0] msg[$]);
        foreach (msg[i])
            send_byte(msg[i], i == msg.size() - 1);
    endtask

    task automatic send_random_msg();
        int unsigned len;
        int unsigned r;
        logic [BYTE_W-1:0] b;
        len = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
        for (int unsigned i = 0; i < len; i++)
        begin
            r = $urandom_range(7);
            // lean on all-ones and zero bytes to hit carries and negative zero
            if (r == 0)
                b = 8'hFF;
            else if (r == 1)
                b = 8'h00;
            else
                b = BYTE_W'($urandom_range(255));
            send_byte(b, i == len - 1);
        end
    endtask

    // sender holds off until every checksum has come out
    task automatic wait_results();
        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_width(input logic [MODE_W-1:0] m);
        wait_results();
        // bytes still in the input register produce no result; let them land
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we    <= 1'b0;
        width_mode = m;
        run_sum    = '0;
        lane_pos   = '0;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_width16_directed();
        // reset width, no write
        send_msg('{8'hFF});
        send_msg('{8'hFF, 8'hFF});              // negative zero
        send_msg('{8'h12, 8'h34, 8'h56});       // short final word
        send_msg('{8'hFF, 8'hFF, 8'h00, 8'h01}); // end-around carry
    endtask

    task automatic test_width8_directed();
        write_width(MODE_W8);
        send_msg('{8'h00});
        send_msg('{8'h80, 8'h80});
        send_msg('{8'hFF});
    endtask

    task automatic test_width32_directed();
        write_width(MODE_W32);
        send_msg('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_msg('{8'hAB});
        send_msg('{8'h01, 8'h02, 8'h03});
    endtask

    task automatic test_spare_code_and_restart();
        write_width(2'd3);
        send_msg('{8'h12, 8'h34});
        // partial message is dropped by the width write
        send_byte(8'h55, 1'b0);
        send_byte(8'h66, 1'b0);
        write_width(MODE_W16);
        send_msg('{8'h77});
    endtask

    task automatic test_random_phase(input logic [MODE_W-1:0] m, input int unsigned n_items);
        int unsigned start;
        bit          paused;
        write_width(m);
        start  = n_bytes;
        paused = 1'b0;
        while (n_bytes - start < n_items)
        begin
            send_random_msg();
            if (!paused && n_bytes - start >= n_items / 2)
            begin
                wait_results();
                paused = 1'b1;
            end
        end
    endtask

    task automatic test_back_to_back(input int unsigned n_items);
        int unsigned start;
        write_width(MODE_W32);
        no_gaps = 1'b1;
        start   = n_bytes;
        while (n_bytes - start < n_items)
            send_random_msg();
        wait_results();
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    always @(negedge clk)
        sum_ch.ready <= no_gaps || ($urandom_range(99) >= 26);

    always @(posedge clk)
    begin
        if (rst_n && sum_ch.valid && sum_ch.ready)
        begin
            if (pending_sums.size() == 0)
            begin
                report_mismatch("unexpected checksum", sum_ch.checksum, '0);
            end
            else
            begin
                logic [SUM_W-1:0] want;
                want = pending_sums.pop_front();
                if (sum_ch.checksum !== want)
                    report_mismatch("checksum", sum_ch.checksum, want);
                n_sums++;
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if ((byte_ch.valid && byte_ch.ready) || (sum_ch.valid && sum_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last_byte = 1'b0;
        no_gaps           = 1'b0;
        n_bytes           = 0;
        width_mode        = MODE_RST;
        run_sum           = '0;
        lane_pos          = '0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_width16_directed();
        test_width8_directed();
        test_width32_directed();
        test_spare_code_and_restart();
        test_random_phase(MODE_W8, 80);
        test_random_phase(MODE_W32, 80);
        test_random_phase(MODE_W16, 70);
        test_random_phase(2'd3, 50);
        test_random_phase(MODE_W_RAND(), 60);
        test_random_phase(MODE_W_RAND(), 60);
        test_back_to_back(120);

        wait_results();
        repeat (8) @(posedge clk);

        $display("covered %0d bytes and %0d checksums over 8/16/32-bit words,", n_bytes, n_sums);
        $display("the spare width code, mid-message width writes and stalls; %0d errors",
                 n_errors);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/occ_pkg.sv
sv/occ_in_if.sv
sv/occ_out_if.sv
sv/occ_input_stage.sv
sv/occ_accum.sv
sv/ones_complement_checksum_core.sv
dv/ones_complement_checksum_core_tb.sv
